@@ hw/rtl/bspc_pkg.sv @@
// ----------------------------------------------------------------------------
// bspc_pkg: shared types and constants of the pairing controller
// Holds the item and result layouts, the register and action codes and the
// reset values of the configuration registers and the pairing state.
// ----------------------------------------------------------------------------
package bspc_pkg;

  localparam int unsigned AddrW = 48;
  localparam int unsigned CntW  = 16;
  localparam int unsigned RssiW = 8;
  localparam int unsigned IdxW  = 2;

  // Actions carried in the input beat
  localparam logic [1:0] ACT_TICK     = 2'd0;
  localparam logic [1:0] ACT_START    = 2'd1;
  localparam logic [1:0] ACT_RESPONSE = 2'd2;

  // Message kinds of a result
  localparam logic [1:0] MSG_NONE  = 2'd0;
  localparam logic [1:0] MSG_BCAST = 2'd1;
  localparam logic [1:0] MSG_RATE  = 2'd2;

  // Configuration register indexes
  localparam logic [IdxW-1:0] REG_WINDOW    = 2'd0;
  localparam logic [IdxW-1:0] REG_BCAST_IVL = 2'd1;
  localparam logic [IdxW-1:0] REG_RATE_IVL  = 2'd2;

  localparam logic [CntW-1:0]  WINDOW_RST    = 16'd500;
  localparam logic [CntW-1:0]  BCAST_IVL_RST = 16'd100;
  localparam logic [CntW-1:0]  RATE_IVL_RST  = 16'd250;
  localparam logic [CntW-1:0]  CNT_MAX       = {CntW{1'b1}};
  localparam logic [AddrW-1:0] BCAST_ADDR    = {AddrW{1'b1}};

  typedef struct packed {
    logic [1:0]              action;
    logic [AddrW-1:0]        sender_address;
    logic signed [RssiW-1:0] signal_strength;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       message_kind;
    logic [AddrW-1:0] destination;
    logic             link_connected;
    logic             pairing_timed_out;
    logic             last_of_run;
  } result_t;

  typedef struct packed {
    logic                    pairing_open;
    logic                    connected;
    logic                    candidate_found;
    logic signed [RssiW-1:0] best_strength;
    logic [AddrW-1:0]        best_address;
    logic [CntW-1:0]         pairing_elapsed;
    logic [CntW-1:0]         broadcast_elapsed;
    logic [CntW-1:0]         request_elapsed;
  } pair_state_t;

  typedef struct packed {
    logic [CntW-1:0] pairing_window_ms;
    logic [CntW-1:0] broadcast_interval_ms;
    logic [CntW-1:0] rate_request_interval_ms;
  } cfg_t;

  // Results of one item, handed to the output queue
  typedef struct packed {
    logic    push;
    logic    two;
    result_t first;
    result_t second;
  } res_push_t;

  localparam pair_state_t STATE_RST = '{
    pairing_open:      1'b0,
    connected:         1'b0,
    candidate_found:   1'b0,
    best_strength:     '0,
    best_address:      '0,
    pairing_elapsed:   '0,
    broadcast_elapsed: CNT_MAX,
    request_elapsed:   CNT_MAX
  };

endpackage

@@ hw/rtl/bspc_core.sv @@
// ----------------------------------------------------------------------------
// bspc_core: next-state and result logic of the pairing controller
// Combinational: from the registered item and the current state it forms
// the next state and the one or two results the item causes.
// ----------------------------------------------------------------------------
module bspc_core (
  input  bspc_pkg::in_item_t    item_i,
  input  bspc_pkg::pair_state_t state_i,
  input  bspc_pkg::cfg_t        cfg_i,
  output bspc_pkg::pair_state_t state_o,
  output logic                  two_o,
  output bspc_pkg::result_t     first_o,
  output bspc_pkg::result_t     second_o
);
  import bspc_pkg::*;

  pair_state_t     st;
  logic            has_a;
  logic            has_b;
  logic [1:0]      kind_a;
  logic [AddrW-1:0] dest_a;
  logic            timed_out;
  logic [CntW-1:0] pe_inc;
  logic [CntW-1:0] be_inc;
  logic [CntW-1:0] re_inc;

  always_comb begin
    pe_inc = (state_i.pairing_elapsed == CNT_MAX) ? CNT_MAX
           : state_i.pairing_elapsed + CntW'(1);
    be_inc = (state_i.broadcast_elapsed == CNT_MAX) ? CNT_MAX
           : state_i.broadcast_elapsed + CntW'(1);
    re_inc = (state_i.request_elapsed == CNT_MAX) ? CNT_MAX
           : state_i.request_elapsed + CntW'(1);
  end

  always_comb begin
    st        = state_i;
    has_a     = 1'b0;
    has_b     = 1'b0;
    kind_a    = MSG_NONE;
    dest_a    = '0;
    timed_out = 1'b0;
    case (item_i.action)
      ACT_TICK: begin
        st.pairing_elapsed   = pe_inc;
        st.broadcast_elapsed = be_inc;
        st.request_elapsed   = re_inc;
        if (state_i.pairing_open) begin
          if (pe_inc > cfg_i.pairing_window_ms) begin
            st.pairing_open = 1'b0;
            if (state_i.candidate_found) begin
              st.connected = 1'b1;
              has_a        = 1'b1;
              kind_a       = MSG_RATE;
              dest_a       = state_i.best_address;
            end else begin
              st.connected = 1'b0;
              timed_out    = 1'b1;
            end
          end else if (be_inc >= cfg_i.broadcast_interval_ms) begin
            st.broadcast_elapsed = '0;
            has_a                = 1'b1;
            kind_a               = MSG_BCAST;
            dest_a               = BCAST_ADDR;
          end
        end
        if (st.connected && re_inc >= cfg_i.rate_request_interval_ms) begin
          st.request_elapsed = '0;
          has_b              = 1'b1;
        end
      end
      ACT_START: begin
        st.candidate_found   = 1'b0;
        st.best_strength     = '0;
        st.best_address      = '0;
        st.connected         = 1'b0;
        st.pairing_open      = 1'b1;
        st.pairing_elapsed   = '0;
        st.broadcast_elapsed = CNT_MAX;
      end
      ACT_RESPONSE: begin
        // keep the strongest responder; ties keep the earlier one
        if (state_i.pairing_open && (!state_i.candidate_found ||
            item_i.signal_strength > state_i.best_strength)) begin
          st.candidate_found = 1'b1;
          st.best_strength   = item_i.signal_strength;
          st.best_address    = item_i.sender_address;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_o = st;
    two_o   = has_a && has_b;

    first_o.message_kind      = has_a ? kind_a : (has_b ? MSG_RATE : MSG_NONE);
    first_o.destination       = has_a ? dest_a : (has_b ? st.best_address : '0);
    first_o.link_connected    = st.connected;
    first_o.pairing_timed_out = timed_out;
    first_o.last_of_run       = !(has_a && has_b);

    second_o.message_kind      = MSG_RATE;
    second_o.destination       = st.best_address;
    second_o.link_connected    = st.connected;
    second_o.pairing_timed_out = timed_out;
    second_o.last_of_run       = 1'b1;
  end

endmodule

@@ hw/rtl/bspc_out_buf.sv @@
// ----------------------------------------------------------------------------
// bspc_out_buf: two-entry result queue
// Takes the one or two results of an item at once and hands them out one
// beat at a time; it takes a new pair while empty or when its last entry drains in the same cycle.
// ----------------------------------------------------------------------------
module bspc_out_buf (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  bspc_pkg::res_push_t   push_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  logic                  ready_i,
  output bspc_pkg::result_t     res_o
);
  import bspc_pkg::*;

  logic [1:0] cnt_q, cnt_d;
  result_t    slot0_q, slot0_d;
  result_t    slot1_q, slot1_d;
  logic       pop;

  assign pop     = (cnt_q != 2'd0) && ready_i;
  assign room_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && ready_i);
  assign valid_o = (cnt_q != 2'd0);
  assign res_o   = slot0_q;

  always_comb begin
    cnt_d   = cnt_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    if (push_i.push) begin
      slot0_d = push_i.first;
      slot1_d = push_i.second;
      cnt_d   = push_i.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      slot0_d = slot1_q;
      cnt_d   = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

@@ hw/rtl/best_signal_pairing_controller.sv @@
// ----------------------------------------------------------------------------
// best_signal_pairing_controller: pairing controller for a sensor link
// Runs the pairing window, picks the strongest responder, sends proximity
// broadcasts while pairing and periodic rate requests once connected.
// ----------------------------------------------------------------------------
//
//  channel  | direction | tdata (low bit up)                     | tuser        | tlast
//  ---------+-----------+----------------------------------------+--------------+------------
//  s_axis   | in        | sender_address, signal_strength        | action       | -
//  m_axis   | out       | destination, link_connected,           | message_kind | last_of_run
//           |           | pairing_timed_out, pad                 |              |
//  cfg      | in        | write enable, index, 16-bit data       | -            | -
//
//  An input beat is held in the input register, then decided
//  combinationally into the two-entry result queue: one beat per cycle when each
//  item yields one result and the output does not stall. An item yielding two
//  results (lock-on request plus periodic rate request on the same tick) fills
//  both queue entries and holds off the next item while both are full.
//  Output stalls back up through the queue into the input register.
//  Reset leaves pairing closed, disconnected, registers at 500/100/250 ms.
//
module best_signal_pairing_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input beats
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [55:0] s_axis_tdata_i,  // [47:0] sender_address, [55:48] signal_strength
  input  logic [1:0]  s_axis_tuser_i,  // [1:0] action
  // result beats
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [55:0] m_axis_tdata_o,  // [47:0] destination, [48] link_connected,
                                       // [49] pairing_timed_out, [55:50] zero
  output logic [1:0]  m_axis_tuser_o,  // [1:0] message_kind
  output logic        m_axis_tlast_o,  // last_of_run
  // configuration writes
  input  logic                      cfg_we_i,
  input  logic [bspc_pkg::IdxW-1:0] cfg_idx_i,
  input  logic [bspc_pkg::CntW-1:0] cfg_data_i
);
  import bspc_pkg::*;

  logic        in_valid_q, in_valid_d;
  in_item_t    in_q, in_d;
  pair_state_t state_q, state_d;
  cfg_t        cfg_q, cfg_d;
  pair_state_t core_state;
  logic        core_two;
  result_t     core_first;
  result_t     core_second;
  res_push_t   push;
  logic        room;
  logic        advance;
  logic        accept;
  result_t     out_res;

  // Advance the held item once the queue has room for its results
  assign advance         = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || advance;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d = in_valid_q;
    in_d       = in_q;
    if (accept) begin
      in_valid_d         = 1'b1;
      in_d.action        = s_axis_tuser_i;
      in_d.sender_address = s_axis_tdata_i[AddrW-1:0];
      in_d.signal_strength = s_axis_tdata_i[AddrW+RssiW-1:AddrW];
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  // Hold configuration; an index past the list is dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW:    cfg_d.pairing_window_ms        = cfg_data_i;
        REG_BCAST_IVL: cfg_d.broadcast_interval_ms    = cfg_data_i;
        REG_RATE_IVL:  cfg_d.rate_request_interval_ms = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign state_d = advance ? core_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      state_q    <= STATE_RST;
      cfg_q      <= '{pairing_window_ms:        WINDOW_RST,
                      broadcast_interval_ms:    BCAST_IVL_RST,
                      rate_request_interval_ms: RATE_IVL_RST};
    end else begin
      in_valid_q <= in_valid_d;
      state_q    <= state_d;
      cfg_q      <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= in_d;
  end

  bspc_core u_core (
    .item_i   (in_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (core_state),
    .two_o    (core_two),
    .first_o  (core_first),
    .second_o (core_second)
  );

  assign push.push   = advance;
  assign push.two    = core_two;
  assign push.first  = core_first;
  assign push.second = core_second;

  bspc_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (out_res)
  );

  assign m_axis_tdata_o = {6'b0, out_res.pairing_timed_out, out_res.link_connected,
                           out_res.destination};
  assign m_axis_tuser_o = out_res.message_kind;
  assign m_axis_tlast_o = out_res.last_of_run;

endmodule

@@ hw/rtl/bspc_checker.sv @@
// ----------------------------------------------------------------------------
// bspc_checker: port-level checks of the pairing controller
// Watches the result channel for held beats and consistent result fields.
// ----------------------------------------------------------------------------
module bspc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [55:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);
  import bspc_pkg::*;

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) &&
      $stable(m_axis_tlast_o))
    else $error("result beat changed while stalled");

  // broadcasts go to all ones and close their run (no link while pairing)
  a_bcast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == MSG_BCAST |->
      m_axis_tdata_o[AddrW-1:0] == BCAST_ADDR && m_axis_tlast_o &&
      !m_axis_tdata_o[AddrW])
    else $error("bad broadcast beat");

  // a status beat stands alone with a zero destination
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == MSG_NONE |->
      m_axis_tlast_o && m_axis_tdata_o[AddrW-1:0] == '0)
    else $error("bad status beat");

  // a timeout never comes with a link
  a_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[AddrW+1] |-> !m_axis_tdata_o[AddrW])
    else $error("timeout reported while connected");

endmodule

bind best_signal_pairing_controller bspc_checker u_bspc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);
